[sv/dual_quadrature_counter_speed_defines.svh]
// Assertion helpers for the quadrature counter block.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef DUAL_QUADRATURE_COUNTER_SPEED_DEFINES_SVH
`define DUAL_QUADRATURE_COUNTER_SPEED_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define DQCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqcs same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define DQCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqcs next-cycle check failed");
`else
`define DQCS_ASSERT_SAME(lbl, ante, cons)
`define DQCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/dqcs_pkg.sv]
package dqcs_pkg;

  localparam int CNT_W     = 32;
  localparam int PWR_W     = 16;
  localparam int TPS_W     = 17;
  localparam int PROD_W    = CNT_W + TPS_W + 1;
  localparam int IN_DATA_W = 72;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 4 * CNT_W;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(10);

  // Item kinds
  typedef enum logic [1:0] {
    OP_EDGE_A = 2'd0,
    OP_EDGE_B = 2'd1,
    OP_TICK   = 2'd2,
    OP_PRESET = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_TPS = 1'b0,
    CFG_SIM = 1'b1
  } cfg_idx_t;

  // After the count update: positions and per-wheel deltas
  typedef struct packed {
    logic                    tick;
    logic signed [CNT_W-1:0] lpos;
    logic signed [CNT_W-1:0] rpos;
    logic signed [CNT_W-1:0] ldelta;
    logic signed [CNT_W-1:0] rdelta;
  } p1_t;

  // After the multiply: positions and raw speed products
  typedef struct packed {
    logic                     tick;
    logic signed [CNT_W-1:0]  lpos;
    logic signed [CNT_W-1:0]  rpos;
    logic signed [PROD_W-1:0] lprod;
    logic signed [PROD_W-1:0] rprod;
  } p2_t;

  // Arithmetic shift right by two, sign extended to count width
  function automatic logic [CNT_W-1:0] power_quarter(input logic [PWR_W-1:0] p);
    return {{(CNT_W-PWR_W+2){p[PWR_W-1]}}, p[PWR_W-1:2]};
  endfunction

  // Clamp a product to the signed 32-bit range
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [PROD_W-1:0] v);
    logic [CNT_W-1:0] res;
    priority if (!v[PROD_W-1] && (|v[PROD_W-2:CNT_W-1])) begin
      res = {1'b0, {(CNT_W-1){1'b1}}};
    end else if (v[PROD_W-1] && !(&v[PROD_W-2:CNT_W-1])) begin
      res = {1'b1, {(CNT_W-1){1'b0}}};
    end else begin
      res = v[CNT_W-1:0];
    end
    return res;
  endfunction

endpackage

[sv/dual_quadrature_counter_speed.sv]
// An accepted request reaches out_tvalid through the count-update, multiply and saturate registers.
// Throughput: one request per cycle while the result side does not stall; the three stages
// advance independently, so bubbles are squeezed out while the result side stalls.
// The delta multiply (32 x 18 signed) sets the middle stage.
// Reset (rst_n low, synchronous): counts, snapshots and speeds clear to zero,
// ticks_per_second returns to 10, simulation mode to on, pipeline empties.
`include "dual_quadrature_counter_speed_defines.svh"

module dual_quadrature_counter_speed (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] pin_a_level, [1] pin_b_level, [33:2] preset_value,
  // [49:34] left_power, [65:50] right_power, [71:66] zero
  input  logic [dqcs_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] opcode, [2] wheel_sel
  input  logic [dqcs_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] left_position, [63:32] right_position,
  // [95:64] left_rate, [127:96] right_rate
  output logic [dqcs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [dqcs_pkg::TPS_W-1:0]       cfg_data
);
  import dqcs_pkg::*;

  // configuration
  logic [TPS_W-1:0] tps_r;
  logic             sim_r;

  // wheel state; acc holds count - snapshot
  logic [CNT_W-1:0] cnt_l_r, cnt_l_nxt, cnt_r_r, cnt_r_nxt;
  logic [CNT_W-1:0] snap_l_r, snap_l_nxt, snap_r_r, snap_r_nxt;
  logic [CNT_W-1:0] acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic [CNT_W-1:0] spd_l_r, spd_r_r;

  // pipeline
  logic p1_v_r, p2_v_r, out_v_r;
  p1_t  p1_r, p1_nxt;
  p2_t  p2_r, p2_nxt;
  logic [CNT_W-1:0] opos_l_r, opos_r_r;
  logic rdy1, rdy2, rdy3, in_fire;

  // request fields
  op_t              op;
  logic             sel, pin_a, pin_b, up;
  logic [CNT_W-1:0] preset, step, lpq, rpq;
  logic [PWR_W-1:0] lpwr, rpwr;

  assign op     = op_t'(in_tuser[1:0]);
  assign sel    = in_tuser[2];
  assign pin_a  = in_tdata[0];
  assign pin_b  = in_tdata[1];
  assign preset = in_tdata[33:2];
  assign lpwr   = in_tdata[49:34];
  assign rpwr   = in_tdata[65:50];

  // stage handshakes
  assign rdy3      = !out_v_r || out_tready;
  assign rdy2      = !p2_v_r || rdy3;
  assign rdy1      = !p1_v_r || rdy2;
  assign in_tready = rdy1;
  assign in_fire   = in_tvalid && rdy1;
  assign cfg_ready = 1'b1;

  // direction and power terms
  assign up   = (pin_a == pin_b) ^ (op == OP_EDGE_B);
  assign step = up ? CNT_W'(1) : {CNT_W{1'b1}};
  assign lpq  = sim_r ? power_quarter(lpwr) : '0;
  assign rpq  = sim_r ? power_quarter(rpwr) : '0;

  // count, snapshot and delta-accumulator update
  always_comb begin
    cnt_l_nxt  = cnt_l_r;
    cnt_r_nxt  = cnt_r_r;
    snap_l_nxt = snap_l_r;
    snap_r_nxt = snap_r_r;
    acc_l_nxt  = acc_l_r;
    acc_r_nxt  = acc_r_r;
    unique case (op)
      OP_EDGE_A, OP_EDGE_B: begin
        if (sel) begin
          cnt_r_nxt = cnt_r_r + step;
          acc_r_nxt = acc_r_r + step;
        end else begin
          cnt_l_nxt = cnt_l_r + step;
          acc_l_nxt = acc_l_r + step;
        end
      end
      OP_TICK: begin
        cnt_l_nxt  = cnt_l_r + lpq;
        cnt_r_nxt  = cnt_r_r + rpq;
        snap_l_nxt = cnt_l_nxt;
        snap_r_nxt = cnt_r_nxt;
        acc_l_nxt  = '0;
        acc_r_nxt  = '0;
      end
      OP_PRESET: begin
        if (sel) begin
          cnt_r_nxt = preset;
          acc_r_nxt = preset - snap_r_r;
        end else begin
          cnt_l_nxt = preset;
          acc_l_nxt = preset - snap_l_r;
        end
      end
      default: ;
    endcase
  end

  // stage 1 payload
  always_comb begin
    p1_nxt.tick   = (op == OP_TICK);
    p1_nxt.lpos   = cnt_l_nxt;
    p1_nxt.rpos   = cnt_r_nxt;
    p1_nxt.ldelta = acc_l_r + lpq;
    p1_nxt.rdelta = acc_r_r + rpq;
  end

  // stage 2 payload: delta times ticks per second
  always_comb begin
    p2_nxt.tick  = p1_r.tick;
    p2_nxt.lpos  = p1_r.lpos;
    p2_nxt.rpos  = p1_r.rpos;
    p2_nxt.lprod = p1_r.ldelta * $signed({1'b0, tps_r});
    p2_nxt.rprod = p1_r.rdelta * $signed({1'b0, tps_r});
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      sim_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TPS: tps_r <= cfg_data;
        CFG_SIM: sim_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // wheel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_l_r  <= '0;
      cnt_r_r  <= '0;
      snap_l_r <= '0;
      snap_r_r <= '0;
      acc_l_r  <= '0;
      acc_r_r  <= '0;
    end else if (in_fire) begin
      cnt_l_r  <= cnt_l_nxt;
      cnt_r_r  <= cnt_r_nxt;
      snap_l_r <= snap_l_nxt;
      snap_r_r <= snap_r_nxt;
      acc_l_r  <= acc_l_nxt;
      acc_r_r  <= acc_r_nxt;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) p1_v_r <= in_tvalid;
      if (rdy2) p2_v_r <= p1_v_r;
      if (rdy3) out_v_r <= p2_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_fire) p1_r <= p1_nxt;
    if (rdy2 && p1_v_r) p2_r <= p2_nxt;
    if (rdy3 && p2_v_r) begin
      opos_l_r <= p2_r.lpos;
      opos_r_r <= p2_r.rpos;
    end
  end

  // speeds: saturated on a tick as it enters the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_l_r <= '0;
      spd_r_r <= '0;
    end else if (rdy3 && p2_v_r && p2_r.tick) begin
      spd_l_r <= sat_cnt(p2_r.lprod);
      spd_r_r <= sat_cnt(p2_r.rprod);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {spd_r_r, spd_l_r, opos_r_r, opos_l_r};

  // checks
  `DQCS_ASSERT_SAME(a_acc_left, 1'b1, acc_l_r == (cnt_l_r - snap_l_r))
  `DQCS_ASSERT_SAME(a_acc_right, 1'b1, acc_r_r == (cnt_r_r - snap_r_r))
  `DQCS_ASSERT_NEXT(a_p2_hold, p2_v_r && !rdy3, p2_v_r && $stable(p2_r))
  `DQCS_ASSERT_NEXT(a_spd_hold, out_v_r && !out_tready, $stable(spd_l_r) && $stable(spd_r_r))

endmodule
